/* hdl/xild_pkg.sv */
// ----------------------------------------------------------------------------
// xild_pkg
// shared constants, window type and stage payload structs for the
// instruction length decoder
// ----------------------------------------------------------------------------
package xild_pkg;

	localparam int WINDOW_BYTES = 15;
	localparam int WINDOW_BITS  = 8 * WINDOW_BYTES;

	typedef logic [WINDOW_BITS-1:0] win_t;

	// opcode and prefix bytes
	localparam logic [7:0] PFX_OPSIZE   = 8'h66;
	localparam logic [7:0] PFX_ADSIZE   = 8'h67;
	localparam logic [7:0] PFX_LOCK     = 8'hf0;
	localparam logic [7:0] PFX_REPNE    = 8'hf2;
	localparam logic [7:0] PFX_REP      = 8'hf3;
	localparam logic [7:0] PFX_CS       = 8'h2e;
	localparam logic [7:0] PFX_SS       = 8'h36;
	localparam logic [7:0] PFX_DS       = 8'h3e;
	localparam logic [7:0] PFX_ES       = 8'h26;
	localparam logic [7:0] PFX_FS       = 8'h64;
	localparam logic [7:0] PFX_GS       = 8'h65;
	localparam logic [3:0] REX_HI       = 4'h4;
	localparam logic [7:0] OP_TWO_BYTE  = 8'h0f;
	localparam logic [7:0] OP_JCC32_LO  = 8'h80;
	localparam logic [7:0] OP_JCC32_HI  = 8'h8f;
	localparam logic [7:0] OP_GRP3_B    = 8'hf6;
	localparam logic [7:0] OP_GRP3_V    = 8'hf7;
	localparam logic [7:0] OP_GRP1_IZ   = 8'h81;
	localparam logic [7:0] OP_MOV_RM_IZ = 8'hc7;
	localparam logic [7:0] OP_MOV_R_LO  = 8'hb8;
	localparam logic [7:0] OP_MOV_R_HI  = 8'hbf;

	localparam logic [7:0] OP_ALU_END    = 8'h40;
	localparam logic [7:0] OP_PUSH_LO    = 8'h50;
	localparam logic [7:0] OP_POP_HI     = 8'h5f;
	localparam logic [7:0] OP_MOVSXD     = 8'h63;
	localparam logic [7:0] OP_PUSH_IZ    = 8'h68;
	localparam logic [7:0] OP_IMUL_IZ    = 8'h69;
	localparam logic [7:0] OP_PUSH_IB    = 8'h6a;
	localparam logic [7:0] OP_IMUL_IB    = 8'h6b;
	localparam logic [7:0] OP_JCC8_LO    = 8'h70;
	localparam logic [7:0] OP_JCC8_HI    = 8'h7f;
	localparam logic [7:0] OP_GRP1_IB    = 8'h80;
	localparam logic [7:0] OP_GRP1_SX    = 8'h83;
	localparam logic [7:0] OP_TEST_B     = 8'h84;
	localparam logic [7:0] OP_TEST_V     = 8'h85;
	localparam logic [7:0] OP_XCHG_B     = 8'h86;
	localparam logic [7:0] OP_XCHG_V     = 8'h87;
	localparam logic [7:0] OP_MOV_LO     = 8'h88;
	localparam logic [7:0] OP_MOV_HI     = 8'h8b;
	localparam logic [7:0] OP_LEA        = 8'h8d;
	localparam logic [7:0] OP_POP_RM     = 8'h8f;
	localparam logic [7:0] OP_NOP        = 8'h90;
	localparam logic [7:0] OP_CWDE       = 8'h98;
	localparam logic [7:0] OP_CDQ        = 8'h99;
	localparam logic [7:0] OP_MOV_R8_LO  = 8'hb0;
	localparam logic [7:0] OP_MOV_R8_HI  = 8'hb7;
	localparam logic [7:0] OP_SHIFT_IB_B = 8'hc0;
	localparam logic [7:0] OP_SHIFT_IB_V = 8'hc1;
	localparam logic [7:0] OP_RET        = 8'hc3;
	localparam logic [7:0] OP_MOV_RM_IB  = 8'hc6;
	localparam logic [7:0] OP_LEAVE      = 8'hc9;
	localparam logic [7:0] OP_INT3       = 8'hcc;
	localparam logic [7:0] OP_SHIFT_LO   = 8'hd0;
	localparam logic [7:0] OP_SHIFT_HI   = 8'hd3;
	localparam logic [7:0] OP_CALL       = 8'he8;
	localparam logic [7:0] OP_JMP32      = 8'he9;
	localparam logic [7:0] OP_JMP8       = 8'heb;
	localparam logic [7:0] OP_HLT        = 8'hf4;
	localparam logic [7:0] OP_GRP5       = 8'hff;

	// low three bits of an alu opcode below 0x40
	localparam logic [2:0] ALU_AL_IB     = 3'd4;
	localparam logic [2:0] ALU_AX_IZ     = 3'd5;

	// modrm and sib fields
	localparam logic [1:0] MOD_IND       = 2'd0;
	localparam logic [1:0] MOD_DISP8     = 2'd1;
	localparam logic [1:0] MOD_DISP32    = 2'd2;
	localparam logic [1:0] MOD_REG       = 2'd3;
	localparam logic [2:0] RM_SIB        = 3'd4;
	localparam logic [2:0] RM_RIP        = 3'd5;
	localparam logic [2:0] SIB_NO_BASE   = 3'd5;

	// stage 1: prefix run measured
	typedef struct packed {
		win_t       win;
		logic [3:0] avail;
		logic [3:0] pfx_len;
		logic       opsize;
	} s1_t;

	// stage 3: opcode decoded, length still relative to opcode start
	typedef struct packed {
		logic [4:0] op_pos;
		logic [3:0] rel_len;
		logic       known;
		logic [3:0] avail;
	} s3_t;

endpackage

/* hdl/xild_prefix.sv */
// ----------------------------------------------------------------------------
// xild_prefix
// stage 1: counts leading legacy prefix bytes and notes an operand-size prefix
// ----------------------------------------------------------------------------
module xild_prefix
	import xild_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       valid_in,
	input  win_t       win,
	input  logic [3:0] avail,
	output logic       valid_s1,
	output s1_t        data_s1
);

	function automatic logic is_pfx(input logic [7:0] b);
		is_pfx = (b == PFX_OPSIZE) || (b == PFX_ADSIZE) || (b == PFX_LOCK) ||
			(b == PFX_REPNE) || (b == PFX_REP) || (b == PFX_CS) ||
			(b == PFX_SS) || (b == PFX_DS) || (b == PFX_ES) ||
			(b == PFX_FS) || (b == PFX_GS);
	endfunction

	logic [3:0] cnt;
	logic       run;
	logic       opsize;

	always_comb begin
		cnt    = '0;
		run    = 1'b1;
		opsize = 1'b0;
		for (int k = 0; k < WINDOW_BYTES; k++) begin
			if (run && is_pfx(win[8*k +: 8])) begin
				cnt = 4'(k + 1);
				if (win[8*k +: 8] == PFX_OPSIZE) begin
					opsize = 1'b1;
				end
			end else begin
				run = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			data_s1.win     <= win;
			data_s1.avail   <= avail;
			data_s1.pfx_len <= cnt;
			data_s1.opsize  <= opsize;
		end
	end

endmodule

/* hdl/xild_align.sv */
// ----------------------------------------------------------------------------
// xild_align
// stage 2: shifts the window so the first byte after the prefixes is byte 0
// ----------------------------------------------------------------------------
module xild_align
	import xild_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_in,
	input  s1_t  data_in,
	output logic valid_s2,
	output s1_t  data_s2
);

	win_t shifted;

	// bytes shifted in from the top read as zero
	assign shifted = data_in.win >> {data_in.pfx_len, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			data_s2.win     <= shifted;
			data_s2.avail   <= data_in.avail;
			data_s2.pfx_len <= data_in.pfx_len;
			data_s2.opsize  <= data_in.opsize;
		end
	end

endmodule

/* hdl/xild_opcode.sv */
// ----------------------------------------------------------------------------
// xild_opcode
// stage 3: rex check and opcode decode, sizes modrm, sib, displacement and
// immediate into a length counted from the opcode byte
// ----------------------------------------------------------------------------
module xild_opcode
	import xild_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_in,
	input  s1_t  data_in,
	output logic valid_s3,
	output s3_t  data_s3
);

	// modrm + sib + displacement bytes
	function automatic logic [2:0] modrm_size(input logic [7:0] m, input logic [7:0] s);
		logic [2:0] n;
		n = 3'd1;
		if (m[7:6] != MOD_REG) begin
			if (m[2:0] == RM_SIB) begin
				n = 3'd2;
				if (m[7:6] == MOD_IND && s[2:0] == SIB_NO_BASE) begin
					n = 3'd6;
				end
			end else if (m[7:6] == MOD_IND && m[2:0] == RM_RIP) begin
				n = 3'd5;
			end
			if (m[7:6] == MOD_DISP8) begin
				n = n + 3'd1;
			end else if (m[7:6] == MOD_DISP32) begin
				n = n + 3'd4;
			end
		end
		modrm_size = n;
	endfunction

	logic       rex;
	logic       rexw;
	win_t       ow;
	logic [7:0] op, o1, o2, o3;
	logic [3:0] ms1, ms2, immz;
	logic [3:0] rel;
	logic       known;
	logic [4:0] op_pos;

	assign rex    = (data_in.win[7:4] == REX_HI);
	assign rexw   = rex & data_in.win[3];
	assign ow     = rex ? (data_in.win >> 8) : data_in.win;
	assign op     = ow[7:0];
	assign o1     = ow[15:8];
	assign o2     = ow[23:16];
	assign o3     = ow[31:24];
	assign ms1    = {1'b0, modrm_size(o1, o2)};
	assign ms2    = {1'b0, modrm_size(o2, o3)};
	assign immz   = data_in.opsize ? 4'd2 : 4'd4;
	assign op_pos = {1'b0, data_in.pfx_len} + {4'd0, rex};

	always_comb begin
		known = 1'b1;
		rel   = 4'd1;
		if (op == OP_TWO_BYTE) begin
			if (o1 >= OP_JCC32_LO && o1 <= OP_JCC32_HI) begin
				rel = 4'd6;
			end else begin
				rel = 4'd2 + ms2;
			end
		end else if ((op >= OP_PUSH_LO && op <= OP_POP_HI) || op == OP_RET ||
			op == OP_LEAVE || op == OP_NOP || op == OP_INT3 || op == OP_HLT ||
			op == OP_CWDE || op == OP_CDQ) begin
			rel = 4'd1;
		end else if (op < OP_ALU_END && op[2:0] <= ALU_AX_IZ) begin
			if (op[2:0] == ALU_AL_IB) begin
				rel = 4'd2;
			end else if (op[2:0] == ALU_AX_IZ) begin
				rel = 4'd1 + immz;
			end else begin
				rel = 4'd1 + ms1;
			end
		end else if ((op >= OP_MOV_LO && op <= OP_MOV_HI) || op == OP_LEA ||
			op == OP_TEST_B || op == OP_TEST_V || op == OP_MOVSXD || op == OP_GRP5 ||
			(op >= OP_SHIFT_LO && op <= OP_SHIFT_HI) || op == OP_XCHG_B ||
			op == OP_XCHG_V || op == OP_POP_RM) begin
			rel = 4'd1 + ms1;
		end else if (op == OP_GRP1_IB || op == OP_GRP1_SX || op == OP_SHIFT_IB_B ||
			op == OP_SHIFT_IB_V || op == OP_MOV_RM_IB || op == OP_IMUL_IB) begin
			rel = 4'd2 + ms1;
		end else if (op == OP_GRP1_IZ || op == OP_MOV_RM_IZ || op == OP_IMUL_IZ) begin
			rel = 4'd1 + ms1 + immz;
		end else if (op == OP_GRP3_B || op == OP_GRP3_V) begin
			// test forms (reg 0 and 1) carry an immediate
			if (o1[5:3] <= 3'd1) begin
				rel = 4'd1 + ms1 + ((op == OP_GRP3_B) ? 4'd1 : immz);
			end else begin
				rel = 4'd1 + ms1;
			end
		end else if ((op >= OP_JCC8_LO && op <= OP_JCC8_HI) || op == OP_JMP8 ||
			(op >= OP_MOV_R8_LO && op <= OP_MOV_R8_HI) || op == OP_PUSH_IB) begin
			rel = 4'd2;
		end else if (op == OP_CALL || op == OP_JMP32 || op == OP_PUSH_IZ) begin
			rel = 4'd5;
		end else if (op >= OP_MOV_R_LO && op <= OP_MOV_R_HI) begin
			rel = rexw ? 4'd9 : (4'd1 + immz);
		end else begin
			known = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			data_s3.op_pos  <= op_pos;
			data_s3.rel_len <= rel;
			data_s3.known   <= known;
			data_s3.avail   <= data_in.avail;
		end
	end

endmodule

/* hdl/x86_instruction_length_decode.sv */
// ----------------------------------------------------------------------------
// x86_instruction_length_decode
// length of one x86-64 instruction (subset) from a 15-byte window
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_stall is low and shows its length on
// the result side after four register stages, the first one loaded at the
// edge that accepts it: prefix count, window align, opcode decode, length
// check into the output register. Sustained rate is one request per
// clock while out_stall is low; out_stall holds the pipeline in place,
// and a stage with no data still accepts, so bubbles close up. A length of 0
// means the instruction is truncated by bytes_available, uses an opcode
// outside the supported subset, or would be longer than 15 bytes. Bytes past
// bytes_available never change the result.
// ----------------------------------------------------------------------------
module x86_instruction_length_decode
	import xild_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] window_low,
	input  logic [55:0] window_high,
	input  logic [3:0]  bytes_available,
	// result side
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  insn_length
);

	logic       valid_s1, valid_s2, valid_s3;
	s1_t        data_s1, data_s2;
	s3_t        data_s3;
	logic       rdy_out, rdy3, rdy2, rdy1;
	logic [4:0] total;
	logic [3:0] len;
	logic       out_valid_q;
	logic [3:0] insn_length_q;

	// each stage moves when it is empty or the stage after it moves
	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy3     = !valid_s3 || rdy_out;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	// stage 1: leading legacy prefixes
	xild_prefix u_prefix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rdy1),
		.valid_in (in_valid),
		.win      ({window_high, window_low}),
		.avail    (bytes_available),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	// stage 2: drop the prefixes from the window
	xild_align u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rdy2),
		.valid_in (valid_s1),
		.data_in  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	// stage 3: rex and opcode
	xild_opcode u_opcode (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rdy3),
		.valid_in (valid_s2),
		.data_in  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	// stage 4: full length; running past the valid bytes covers every
	// truncation case, and avail never exceeds 15
	assign total = data_s3.op_pos + {1'b0, data_s3.rel_len};
	assign len   = (data_s3.known && total <= {1'b0, data_s3.avail}) ? total[3:0] : 4'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && valid_s3) begin
			insn_length_q <= len;
		end
	end

	assign out_valid   = out_valid_q;
	assign insn_length = insn_length_q;

endmodule
